@@ rtl/core/rss_pkg.sv @@
package rss_pkg;

    localparam int DEF_MAX_COUNT   = 4096;
    localparam int DEF_SAMPLE_BITS = 24;

    // Fixed-point layout
    localparam int MEAN_FRAC  = 16;
    localparam int PROD_SHIFT = 28;
    localparam int MUL_CHUNK  = 16;
    localparam int ACC_W      = 64;

    // Iterative divide / square-root unit
    localparam int DIV_W  = 64;
    localparam int ROOT_W = 32;
    localparam int STEP_W = 7;

    localparam logic [STEP_W-1:0] RPT_DIV_STEPS = STEP_W'(DIV_W);
    localparam logic [STEP_W-1:0] SQRT_STEPS    = STEP_W'(ROOT_W);
    localparam logic [DIV_W-1:0]  SQRT_TOP_BIT  = DIV_W'(1) << (DIV_W - 2);

    typedef enum logic [0:0] {
        OP_ADD    = 1'b0,
        OP_REPORT = 1'b1
    } rss_op_t;

    typedef enum logic [0:0] {
        ITER_DIV  = 1'b0,
        ITER_SQRT = 1'b1
    } rss_iter_mode_t;

    typedef struct packed {
        logic                start;
        rss_iter_mode_t      mode;
        logic [STEP_W-1:0]   steps;
    } rss_iter_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } rss_iter_sts_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_UPDATE,
        ST_MUL,
        ST_ACC,
        ST_RPT_START,
        ST_RPT_DIV,
        ST_SQRT_START,
        ST_SQRT_WAIT,
        ST_RPT_DONE
    } rss_state_t;

endpackage

@@ rtl/core/rss_item_if.sv @@
interface rss_item_if #(
    parameter int SAMPLE_BITS = rss_pkg::DEF_SAMPLE_BITS
);
    logic                   valid;
    logic                   ready;
    logic                   op;
    logic [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output op, output sample, input ready);
    modport sink   (input valid, input op, input sample, output ready);
endinterface

@@ rtl/core/rss_result_if.sv @@
interface rss_result_if #(
    parameter int CNT_W       = $clog2(rss_pkg::DEF_MAX_COUNT + 1),
    parameter int SAMPLE_BITS = rss_pkg::DEF_SAMPLE_BITS
);
    logic                   valid;
    logic                   ready;
    logic [CNT_W-1:0]       sample_count;
    logic [SAMPLE_BITS-1:0] min_value;
    logic [SAMPLE_BITS-1:0] max_value;
    logic [SAMPLE_BITS-1:0] mean_value;
    logic [SAMPLE_BITS-1:0] std_dev;
    logic                   dropped;

    modport source (
        output valid, output sample_count, output min_value, output max_value,
        output mean_value, output std_dev, output dropped, input ready
    );
    modport sink (
        input valid, input sample_count, input min_value, input max_value,
        input mean_value, input std_dev, input dropped, output ready
    );
endinterface

@@ rtl/core/rss_iter_unit.sv @@
module rss_iter_unit #(
    parameter int CNT_W = $clog2(rss_pkg::DEF_MAX_COUNT + 1)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  rss_pkg::rss_iter_ctl_t       ctl,
    input  logic [rss_pkg::DIV_W-1:0]    arg,
    input  logic [CNT_W-1:0]             divisor,
    output rss_pkg::rss_iter_sts_t       sts,
    output logic [rss_pkg::DIV_W-1:0]    quotient,
    output logic [CNT_W-1:0]             remainder,
    output logic [rss_pkg::ROOT_W-1:0]   root
);
    localparam int DIV_W = rss_pkg::DIV_W;
    localparam int SUB_W = DIV_W + 1;

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    rss_pkg::rss_iter_mode_t       mode_reg, mode_next;
    logic [rss_pkg::STEP_W-1:0]    step_reg, step_next;
    logic [rss_pkg::STEP_W-1:0]    last_reg, last_next;
    logic [DIV_W-1:0]              quo_reg, quo_next;
    logic [CNT_W-1:0]              rem_reg, rem_next;
    logic [DIV_W-1:0]              res_reg, res_next;
    logic [DIV_W-1:0]              bit_reg, bit_next;

    logic [CNT_W:0]                partial;
    logic [DIV_W-1:0]              trial;
    logic [SUB_W-1:0]              op_a, op_b, diff;
    logic                          fits;

    // One subtractor serves both the restoring divide and the digit-by-digit root
    always_comb
    begin
        partial = {rem_reg, quo_reg[DIV_W-1]};
        trial   = res_reg | bit_reg;
        unique case (mode_reg)
            rss_pkg::ITER_DIV:
            begin
                op_a = SUB_W'(partial);
                op_b = SUB_W'(divisor);
            end
            rss_pkg::ITER_SQRT:
            begin
                op_a = {1'b0, quo_reg};
                op_b = {1'b0, trial};
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
        diff = op_a - op_b;
        fits = ~diff[SUB_W-1];
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        mode_next = mode_reg;
        step_next = step_reg;
        last_next = last_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        if (ctl.start)
        begin
            busy_next = 1'b1;
            mode_next = ctl.mode;
            step_next = '0;
            last_next = ctl.steps - rss_pkg::STEP_W'(1);
            quo_next  = arg;
            rem_next  = '0;
            res_next  = '0;
            bit_next  = rss_pkg::SQRT_TOP_BIT;
        end
        else if (busy_reg)
        begin
            unique case (mode_reg)
                rss_pkg::ITER_DIV:
                begin
                    quo_next = {quo_reg[DIV_W-2:0], fits};
                    rem_next = fits ? diff[CNT_W-1:0] : partial[CNT_W-1:0];
                end
                rss_pkg::ITER_SQRT:
                begin
                    if (fits)
                    begin
                        quo_next = diff[DIV_W-1:0];
                        res_next = (res_reg >> 1) | bit_reg;
                    end
                    else
                    begin
                        res_next = res_reg >> 1;
                    end
                    bit_next = bit_reg >> 2;
                end
                default:
                begin
                    quo_next = quo_reg;
                end
            endcase
            step_next = step_reg + rss_pkg::STEP_W'(1);
            if (step_reg == last_reg)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            mode_reg <= rss_pkg::ITER_DIV;
            step_reg <= '0;
            last_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            mode_reg <= mode_next;
            step_reg <= step_next;
            last_reg <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign sts.busy  = busy_reg;
    assign sts.done  = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign root      = res_reg[rss_pkg::ROOT_W-1:0];

endmodule

@@ rtl/core/running_sample_statistics_core.sv @@
// Channel   Direction  Transaction payload
// item      in         op, sample
// result    out        sample_count, min_value, max_value, mean_value, std_dev, dropped
//
// A sample runs a restoring divide, one quotient bit a cycle, then the multiply in
//   16-bit slices.
// A report runs 64 divide and 32 root steps on the shared unit (only the root steps for a
//   count of 0 or 1), and holds while the result register is still full.
// A sample that meets a full count is dropped in its accept cycle.
// rst_n clears the whole store asynchronously; a report clears it as well.
module running_sample_statistics_core #(
    parameter int MAX_COUNT   = rss_pkg::DEF_MAX_COUNT,
    parameter int SAMPLE_BITS = rss_pkg::DEF_SAMPLE_BITS
) (
    input  logic          clk,
    input  logic          rst_n,
    rss_item_if.sink      item,
    rss_result_if.source  result
);
    localparam int CNT_W      = $clog2(MAX_COUNT + 1);
    localparam int MEAN_FRAC  = rss_pkg::MEAN_FRAC;
    localparam int MEAN_W     = SAMPLE_BITS + MEAN_FRAC;
    localparam int MUL_CHUNK  = rss_pkg::MUL_CHUNK;
    localparam int MUL_STEPS  = (MEAN_W + MUL_CHUNK - 1) / MUL_CHUNK;
    localparam int MAG_PAD    = MUL_STEPS * MUL_CHUNK;
    localparam int PROD_W     = MEAN_W + MAG_PAD;
    localparam int PROD_SHIFT = rss_pkg::PROD_SHIFT;
    localparam int TERM_W     = PROD_W - PROD_SHIFT;
    localparam int ACC_W      = rss_pkg::ACC_W;
    localparam int SUM_W      = ((TERM_W > ACC_W) ? TERM_W : ACC_W) + 1;
    localparam int MCNT_W     = $clog2(MUL_STEPS + 1);
    localparam int DIV_W      = rss_pkg::DIV_W;
    localparam int ROOT_W     = rss_pkg::ROOT_W;
    localparam int ALIGN      = DIV_W - MEAN_W;

    localparam logic [CNT_W-1:0]       COUNT_FULL  = CNT_W'(MAX_COUNT);
    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX  = {SAMPLE_BITS{1'b1}};
    localparam logic [MEAN_W:0]        MEAN_HALF   = (MEAN_W + 1)'(1) << (MEAN_FRAC - 1);
    localparam logic [MCNT_W-1:0]      MUL_LAST    = MCNT_W'(MUL_STEPS - 1);

    rss_pkg::rss_state_t       state_reg, state_next;

    logic [CNT_W-1:0]          count_reg, count_next;
    logic [SAMPLE_BITS-1:0]    min_reg, min_next;
    logic [SAMPLE_BITS-1:0]    max_reg, max_next;
    logic [MEAN_W-1:0]         mean_acc_reg, mean_acc_next;
    logic [ACC_W-1:0]          sq_dev_acc_reg, sq_dev_acc_next;
    logic                      drop_flag_reg, drop_flag_next;

    logic [MEAN_W-1:0]         mag_reg, mag_next;
    logic                      up_reg, up_next;
    logic [MEAN_W-1:0]         q_reg, q_next;
    logic [MEAN_W-1:0]         e_reg, e_next;
    logic [MAG_PAD-1:0]        pad_reg, pad_next;
    logic [PROD_W-1:0]         prod_reg, prod_next;
    logic [MCNT_W-1:0]         mul_cnt_reg, mul_cnt_next;
    logic [CNT_W-1:0]          div_reg, div_next;
    logic [DIV_W-1:0]          arg_reg, arg_next;
    logic [SAMPLE_BITS-1:0]    sd_reg, sd_next;

    logic                      result_valid_reg, result_valid_next;
    logic [CNT_W-1:0]          out_count_reg, out_count_next;
    logic [SAMPLE_BITS-1:0]    out_min_reg, out_min_next;
    logic [SAMPLE_BITS-1:0]    out_max_reg, out_max_next;
    logic [SAMPLE_BITS-1:0]    out_mean_reg, out_mean_next;
    logic [SAMPLE_BITS-1:0]    out_sd_reg, out_sd_next;
    logic                      out_drop_reg, out_drop_next;

    rss_pkg::rss_iter_ctl_t    iter_ctl;
    rss_pkg::rss_iter_sts_t    iter_sts;
    logic [DIV_W-1:0]          iter_quo;
    logic [CNT_W-1:0]          iter_rem;
    logic [ROOT_W-1:0]         iter_root;

    logic                      item_fire;
    logic                      out_load;
    logic [SAMPLE_BITS-1:0]    x;
    logic [MEAN_W-1:0]         xs;
    logic                      up_calc;
    logic [MEAN_W-1:0]         mag_calc;
    logic                      round_up;
    logic [MEAN_W+MUL_CHUNK-1:0] partial_prod;
    logic [SUM_W-1:0]          acc_sum;
    logic [ROOT_W:0]           root_sum;
    logic [ROOT_W:0]           sd_full;
    logic [MEAN_W:0]           mean_round;
    logic [SAMPLE_BITS:0]      mean_int;

    rss_iter_unit #(
        .CNT_W (CNT_W)
    ) u_iter (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (iter_ctl),
        .arg       (arg_reg),
        .divisor   (div_reg),
        .sts       (iter_sts),
        .quotient  (iter_quo),
        .remainder (iter_rem),
        .root      (iter_root)
    );

    assign item.ready = (state_reg == rss_pkg::ST_IDLE);
    assign item_fire  = item.valid && item.ready;
    assign out_load   = !result_valid_reg || result.ready;

    always_comb
    begin
        x            = item.sample[SAMPLE_BITS-1:0];
        xs           = {x, {MEAN_FRAC{1'b0}}};
        up_calc      = (xs >= mean_acc_reg);
        mag_calc     = up_calc ? (xs - mean_acc_reg) : (mean_acc_reg - xs);
        // Round half away from zero on the magnitude: 2r >= d
        round_up     = ({iter_rem, 1'b0} >= {1'b0, div_reg});
        partial_prod = e_reg * pad_reg[MAG_PAD-1 -: MUL_CHUNK];
        acc_sum      = SUM_W'(sq_dev_acc_reg) + SUM_W'(prod_reg[PROD_W-1:PROD_SHIFT]);
        root_sum     = (ROOT_W + 1)'(iter_root) + (ROOT_W + 1)'(2);
        sd_full      = root_sum >> 2;
        mean_round   = (MEAN_W + 1)'(mean_acc_reg) + MEAN_HALF;
        mean_int     = mean_round[MEAN_W:MEAN_FRAC];
    end

    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        min_next          = min_reg;
        max_next          = max_reg;
        mean_acc_next     = mean_acc_reg;
        sq_dev_acc_next   = sq_dev_acc_reg;
        drop_flag_next    = drop_flag_reg;
        mag_next          = mag_reg;
        up_next           = up_reg;
        q_next            = q_reg;
        e_next            = e_reg;
        pad_next          = pad_reg;
        prod_next         = prod_reg;
        mul_cnt_next      = mul_cnt_reg;
        div_next          = div_reg;
        arg_next          = arg_reg;
        sd_next           = sd_reg;
        result_valid_next = result_valid_reg;
        out_count_next    = out_count_reg;
        out_min_next      = out_min_reg;
        out_max_next      = out_max_reg;
        out_mean_next     = out_mean_reg;
        out_sd_next       = out_sd_reg;
        out_drop_next     = out_drop_reg;
        iter_ctl.start    = 1'b0;
        iter_ctl.mode     = rss_pkg::ITER_DIV;
        iter_ctl.steps    = rss_pkg::STEP_W'(MEAN_W);

        if (result_valid_reg && result.ready)
        begin
            result_valid_next = 1'b0;
        end

        unique case (state_reg)
            rss_pkg::ST_IDLE:
            begin
                if (item_fire)
                begin
                    if (item.op == rss_pkg::OP_REPORT)
                    begin
                        div_next   = count_reg - CNT_W'(1);
                        arg_next   = sq_dev_acc_reg;
                        state_next = rss_pkg::ST_RPT_START;
                    end
                    else if (count_reg >= COUNT_FULL)
                    begin
                        drop_flag_next = 1'b1;
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            min_next = x;
                            max_next = x;
                        end
                        else
                        begin
                            if (x < min_reg)
                            begin
                                min_next = x;
                            end
                            if (x > max_reg)
                            begin
                                max_next = x;
                            end
                        end
                        count_next = count_reg + CNT_W'(1);
                        div_next   = count_reg + CNT_W'(1);
                        up_next    = up_calc;
                        mag_next   = mag_calc;
                        // Left-align the magnitude so only MEAN_W divide steps are needed
                        arg_next   = DIV_W'(mag_calc) << ALIGN;
                        state_next = rss_pkg::ST_DIV_START;
                    end
                end
            end
            rss_pkg::ST_DIV_START:
            begin
                iter_ctl.start = 1'b1;
                iter_ctl.mode  = rss_pkg::ITER_DIV;
                iter_ctl.steps = rss_pkg::STEP_W'(MEAN_W);
                state_next     = rss_pkg::ST_DIV_WAIT;
            end
            rss_pkg::ST_DIV_WAIT:
            begin
                if (iter_sts.done)
                begin
                    q_next     = iter_quo[MEAN_W-1:0] + MEAN_W'(round_up);
                    state_next = rss_pkg::ST_UPDATE;
                end
            end
            rss_pkg::ST_UPDATE:
            begin
                mean_acc_next = up_reg ? (mean_acc_reg + q_reg) : (mean_acc_reg - q_reg);
                e_next        = mag_reg - q_reg;
                pad_next      = MAG_PAD'(mag_reg);
                prod_next     = '0;
                mul_cnt_next  = '0;
                state_next    = rss_pkg::ST_MUL;
            end
            rss_pkg::ST_MUL:
            begin
                // Consume the magnitude one slice a cycle, most significant first
                prod_next    = PROD_W'(prod_reg << MUL_CHUNK) + PROD_W'(partial_prod);
                pad_next     = pad_reg << MUL_CHUNK;
                mul_cnt_next = mul_cnt_reg + MCNT_W'(1);
                if (mul_cnt_reg == MUL_LAST)
                begin
                    state_next = rss_pkg::ST_ACC;
                end
            end
            rss_pkg::ST_ACC:
            begin
                if (acc_sum[SUM_W-1:ACC_W] != '0)
                begin
                    sq_dev_acc_next = {ACC_W{1'b1}};
                end
                else
                begin
                    sq_dev_acc_next = acc_sum[ACC_W-1:0];
                end
                state_next = rss_pkg::ST_IDLE;
            end
            rss_pkg::ST_RPT_START:
            begin
                iter_ctl.start = 1'b1;
                if (count_reg > CNT_W'(1))
                begin
                    iter_ctl.mode  = rss_pkg::ITER_DIV;
                    iter_ctl.steps = rss_pkg::RPT_DIV_STEPS;
                    state_next     = rss_pkg::ST_RPT_DIV;
                end
                else
                begin
                    iter_ctl.mode  = rss_pkg::ITER_SQRT;
                    iter_ctl.steps = rss_pkg::SQRT_STEPS;
                    state_next     = rss_pkg::ST_SQRT_WAIT;
                end
            end
            rss_pkg::ST_RPT_DIV:
            begin
                if (iter_sts.done)
                begin
                    arg_next   = iter_quo + DIV_W'(round_up);
                    state_next = rss_pkg::ST_SQRT_START;
                end
            end
            rss_pkg::ST_SQRT_START:
            begin
                iter_ctl.start = 1'b1;
                iter_ctl.mode  = rss_pkg::ITER_SQRT;
                iter_ctl.steps = rss_pkg::SQRT_STEPS;
                state_next     = rss_pkg::ST_SQRT_WAIT;
            end
            rss_pkg::ST_SQRT_WAIT:
            begin
                if (iter_sts.done)
                begin
                    if (sd_full > (ROOT_W + 1)'(SAMPLE_MAX))
                    begin
                        sd_next = SAMPLE_MAX;
                    end
                    else
                    begin
                        sd_next = sd_full[SAMPLE_BITS-1:0];
                    end
                    state_next = rss_pkg::ST_RPT_DONE;
                end
            end
            rss_pkg::ST_RPT_DONE:
            begin
                // Hold until the result register is free, then clear the store
                if (out_load)
                begin
                    result_valid_next = 1'b1;
                    out_count_next    = count_reg;
                    out_min_next      = min_reg;
                    out_max_next      = max_reg;
                    out_mean_next     = mean_int[SAMPLE_BITS] ? SAMPLE_MAX
                                                              : mean_int[SAMPLE_BITS-1:0];
                    out_sd_next       = sd_reg;
                    out_drop_next     = drop_flag_reg;
                    count_next        = '0;
                    min_next          = '0;
                    max_next          = '0;
                    mean_acc_next     = '0;
                    sq_dev_acc_next   = '0;
                    drop_flag_next    = 1'b0;
                    state_next        = rss_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rss_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= rss_pkg::ST_IDLE;
            count_reg        <= '0;
            min_reg          <= '0;
            max_reg          <= '0;
            mean_acc_reg     <= '0;
            sq_dev_acc_reg   <= '0;
            drop_flag_reg    <= 1'b0;
            mul_cnt_reg      <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            min_reg          <= min_next;
            max_reg          <= max_next;
            mean_acc_reg     <= mean_acc_next;
            sq_dev_acc_reg   <= sq_dev_acc_next;
            drop_flag_reg    <= drop_flag_next;
            mul_cnt_reg      <= mul_cnt_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg       <= mag_next;
        up_reg        <= up_next;
        q_reg         <= q_next;
        e_reg         <= e_next;
        pad_reg       <= pad_next;
        prod_reg      <= prod_next;
        div_reg       <= div_next;
        arg_reg       <= arg_next;
        sd_reg        <= sd_next;
        out_count_reg <= out_count_next;
        out_min_reg   <= out_min_next;
        out_max_reg   <= out_max_next;
        out_mean_reg  <= out_mean_next;
        out_sd_reg    <= out_sd_next;
        out_drop_reg  <= out_drop_next;
    end

    assign result.valid        = result_valid_reg;
    assign result.sample_count = out_count_reg;
    assign result.min_value    = out_min_reg;
    assign result.max_value    = out_max_reg;
    assign result.mean_value   = out_mean_reg;
    assign result.std_dev      = out_sd_reg;
    assign result.dropped      = out_drop_reg;

    a_report_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (item_fire && item.op == rss_pkg::OP_REPORT) |=> !item.ready)
        else $error("report transaction did not start the report sequence");

    a_clear_on_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rss_pkg::ST_RPT_DONE && out_load)
            |=> (count_reg == '0 && result.valid && item.ready))
        else $error("store not cleared after report was loaded");

    a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) |-> (min_reg <= max_reg))
        else $error("minimum above maximum");

    a_mean_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rss_pkg::ST_IDLE && count_reg != '0)
            |-> (mean_acc_reg <= {max_reg, {MEAN_FRAC{1'b0}}}
                 && mean_acc_reg >= {min_reg, {MEAN_FRAC{1'b0}}}))
        else $error("running mean outside sample range");

    a_iter_owned: assert property (@(posedge clk) disable iff (!rst_n)
        iter_sts.busy |-> (state_reg == rss_pkg::ST_DIV_WAIT
                           || state_reg == rss_pkg::ST_RPT_DIV
                           || state_reg == rss_pkg::ST_SQRT_WAIT))
        else $error("shared unit busy outside a wait state");

endmodule

@@ verif/testbench.sv @@
module testbench;

    localparam int SAMPLE_BITS = rss_pkg::DEF_SAMPLE_BITS;
    localparam int MAX_COUNT   = rss_pkg::DEF_MAX_COUNT;
    localparam int CNT_W       = $clog2(MAX_COUNT + 1);
    localparam int MEAN_FRAC   = rss_pkg::MEAN_FRAC;
    localparam int PROD_SHIFT  = rss_pkg::PROD_SHIFT;
    localparam logic [63:0] SAMPLE_MAX = (64'd1 << SAMPLE_BITS) - 64'd1;

    localparam int RANDOM_ITEMS = 1150;
    localparam int IDLE_PCT     = 21;
    localparam int CALM_FROM    = 3000;
    localparam int CALM_TO      = 15000;
    localparam int QUIET_LIMIT  = 3000;
    localparam int SETTLE_CYCLES = 300;

    typedef struct packed {
        rss_pkg::rss_op_t       op;
        logic [SAMPLE_BITS-1:0] sample;
    } stat_item_t;

    typedef struct packed {
        logic [CNT_W-1:0]       sample_count;
        logic [SAMPLE_BITS-1:0] min_value;
        logic [SAMPLE_BITS-1:0] max_value;
        logic [SAMPLE_BITS-1:0] mean_value;
        logic [SAMPLE_BITS-1:0] std_dev;
        logic                   dropped;
    } stat_report_t;

    logic clk = 1'b0;
    logic rst_n;

    rss_item_if   #(.SAMPLE_BITS(SAMPLE_BITS)) item_ch ();
    rss_result_if #(.CNT_W(CNT_W), .SAMPLE_BITS(SAMPLE_BITS)) result_ch ();

    running_sample_statistics_core #(
        .MAX_COUNT   (MAX_COUNT),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    stat_item_t   item_backlog[$];
    stat_report_t pending_reports[$];
    int           fail_count = 0;
    int           quiet_cycles = 0;
    int           cycle_count = 0;

    // Running statistics held by the predictor
    logic [CNT_W-1:0]       acc_count;
    logic [SAMPLE_BITS-1:0] acc_min;
    logic [SAMPLE_BITS-1:0] acc_max;
    logic [63:0]            acc_mean;
    logic [63:0]            acc_sqdev;
    logic                   acc_dropped;

    function automatic void clear_stats();
        acc_count   = '0;
        acc_min     = '0;
        acc_max     = '0;
        acc_mean    = '0;
        acc_sqdev   = '0;
        acc_dropped = 1'b0;
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [31:0] root;
        logic [31:0] trial;
        root = '0;
        for (int b = 31; b >= 0; b--)
        begin
            trial = root | (32'd1 << b);
            if (64'(trial) * 64'(trial) <= v)
                root = trial;
        end
        return 64'(root);
    endfunction

    // Welford update: mean in Q.16, deviation sum in Q60.4
    function automatic void fold_sample(logic [SAMPLE_BITS-1:0] x);
        logic [63:0]  xs;
        logic [63:0]  mag;
        logic [63:0]  n;
        logic [63:0]  q;
        logic [63:0]  r;
        logic [63:0]  e;
        logic [63:0]  term;
        logic [127:0] prod;
        logic [64:0]  total;
        logic         up;
        if (acc_count >= MAX_COUNT)
        begin
            acc_dropped = 1'b1;
            return;
        end
        if (acc_count == 0)
        begin
            acc_min = x;
            acc_max = x;
        end
        else
        begin
            if (x < acc_min)
                acc_min = x;
            if (x > acc_max)
                acc_max = x;
        end
        acc_count = acc_count + 1'b1;
        n  = 64'(acc_count);
        xs = 64'(x) << MEAN_FRAC;
        up = (xs >= acc_mean);
        mag = up ? xs - acc_mean : acc_mean - xs;
        q = mag / n;
        r = mag % n;
        // round to nearest, ties away from zero
        if (r >= n - r)
            q = q + 64'd1;
        acc_mean = up ? acc_mean + q : acc_mean - q;
        e = mag - q;
        prod = 128'(mag) * 128'(e);
        if (prod[127:64+PROD_SHIFT] != '0)
            term = '1;
        else
            term = prod[63+PROD_SHIFT:PROD_SHIFT];
        total = {1'b0, acc_sqdev} + {1'b0, term};
        acc_sqdev = total[64] ? '1 : total[63:0];
    endfunction

    function automatic stat_report_t close_report();
        stat_report_t rpt;
        logic [63:0]  v;
        logic [63:0]  d;
        logic [63:0]  r;
        logic [63:0]  sd;
        logic [63:0]  mean_out;
        v = acc_sqdev;
        if (acc_count > 1)
        begin
            d = 64'(acc_count) - 64'd1;
            r = v % d;
            v = v / d;
            if (r >= d - r)
                v = v + 64'd1;
        end
        sd = (int_sqrt(v) + 64'd2) / 64'd4;
        if (sd > SAMPLE_MAX)
            sd = SAMPLE_MAX;
        mean_out = (acc_mean + (64'd1 << (MEAN_FRAC - 1))) >> MEAN_FRAC;
        if (mean_out > SAMPLE_MAX)
            mean_out = SAMPLE_MAX;
        rpt.sample_count = acc_count;
        rpt.min_value    = acc_min;
        rpt.max_value    = acc_max;
        rpt.mean_value   = mean_out[SAMPLE_BITS-1:0];
        rpt.std_dev      = sd[SAMPLE_BITS-1:0];
        rpt.dropped      = acc_dropped;
        clear_stats();
        return rpt;
    endfunction

    function automatic bit take_idle();
        bit calm;
        calm = (cycle_count >= CALM_FROM) && (cycle_count < CALM_TO);
        return !calm && ($urandom_range(99) < IDLE_PCT);
    endfunction

    // Sender: hold each transaction until it is taken, then advance
    always @(posedge clk or negedge rst_n)
    begin
        stat_item_t next_item;
        logic       load;
        if (!rst_n)
        begin
            item_ch.valid  <= 1'b0;
            item_ch.op     <= 1'b0;
            item_ch.sample <= '0;
            clear_stats();
        end
        else
        begin
            load = 1'b0;
            if (item_ch.valid && item_ch.ready)
            begin
                if (item_ch.op == rss_pkg::OP_REPORT)
                    pending_reports.push_back(close_report());
                else
                    fold_sample(item_ch.sample);
            end
            if (!item_ch.valid || item_ch.ready)
            begin
                if (item_backlog.size() != 0 && !take_idle())
                begin
                    next_item = item_backlog.pop_front();
                    load = 1'b1;
                    item_ch.op     <= next_item.op;
                    item_ch.sample <= next_item.sample;
                end
                item_ch.valid <= load;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else
            result_ch.ready <= !take_idle();
    end

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        stat_report_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_reports.size() == 0)
            begin
                $error("result transaction with no report pending");
                fail_count++;
            end
            else
            begin
                want = pending_reports.pop_front();
                check_field("sample_count", 64'(want.sample_count),
                            64'(result_ch.sample_count));
                check_field("min_value", 64'(want.min_value), 64'(result_ch.min_value));
                check_field("max_value", 64'(want.max_value), 64'(result_ch.max_value));
                check_field("mean_value", 64'(want.mean_value), 64'(result_ch.mean_value));
                check_field("std_dev", 64'(want.std_dev), 64'(result_ch.std_dev));
                check_field("dropped", 64'(want.dropped), 64'(result_ch.dropped));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    task automatic queue_sample(logic [SAMPLE_BITS-1:0] x);
        item_backlog.push_back('{op: rss_pkg::OP_ADD, sample: x});
    endtask

    task automatic queue_report();
        item_backlog.push_back('{op: rss_pkg::OP_REPORT, sample: SAMPLE_BITS'($urandom())});
    endtask

    // Wait until every transaction is sent and every report has come back
    task automatic drain_all();
        while (item_backlog.size() != 0 || item_ch.valid || pending_reports.size() != 0)
            @(negedge clk);
    endtask

    function automatic logic [SAMPLE_BITS-1:0] pick_value(int style);
        case (style)
            0: return SAMPLE_BITS'($urandom());
            1: return SAMPLE_BITS'($urandom_range(0, int'(SAMPLE_MAX) - 64)
                                   + $urandom_range(0, 63));
            2: return $urandom_range(0, 1) ? SAMPLE_MAX[SAMPLE_BITS-1:0] : '0;
            3: return SAMPLE_BITS'($urandom_range(0, 7));
            default: return SAMPLE_BITS'(SAMPLE_MAX - 64'($urandom_range(0, 255)));
        endcase
    endfunction

    initial
    begin
        int random_items;
        int set_len;
        int style;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty report, with the sample field set to be ignored
        item_backlog.push_back('{op: rss_pkg::OP_REPORT,
                                 sample: SAMPLE_MAX[SAMPLE_BITS-1:0]});
        queue_sample('0);
        queue_report();
        queue_sample(SAMPLE_MAX[SAMPLE_BITS-1:0]);
        queue_sample('0);
        queue_report();
        repeat (3) queue_sample(SAMPLE_MAX[SAMPLE_BITS-1:0]);
        queue_report();
        // mean of 1.5 rounds half up
        queue_sample(SAMPLE_BITS'(1));
        queue_sample(SAMPLE_BITS'(2));
        queue_report();
        queue_sample(SAMPLE_BITS'(5));
        queue_sample(SAMPLE_BITS'(6));
        queue_sample(SAMPLE_BITS'(9));
        queue_report();
        queue_report();
        drain_all();

        random_items = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            if ($urandom_range(9) == 0)
                set_len = $urandom_range(13, 120);
            else if ($urandom_range(11) == 0)
                set_len = 0;
            else
                set_len = $urandom_range(1, 12);
            style = $urandom_range(0, 4);
            repeat (set_len)
            begin
                queue_sample(pick_value($urandom_range(3) == 0 ? $urandom_range(0, 4) : style));
            end
            queue_report();
            random_items += set_len + 1;
            while (item_backlog.size() > 64)
                @(negedge clk);
        end

        drain_all();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_reports.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
